/* design/pib_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pib_pkg
// Shared types and constants of the particle integrate and bounce block.
// ----------------------------------------------------------------------------
package pib_pkg;

    localparam int POS_W = 32;
    localparam int VEL_W = 40;
    localparam int FRC_W = 48;
    localparam int DT_W  = 24;

    typedef struct packed {
        logic [23:0] time_step;
        logic [15:0] wall_damping;
        logic [15:0] velocity_decay;
        logic [23:0] gravity_accel;
        logic [15:0] area_width;
        logic [15:0] area_height;
        logic [7:0]  edge_offset;
    } pib_cfg_t;

    typedef enum logic [2:0] {
        REG_TIME_STEP      = 3'd0,
        REG_WALL_DAMPING   = 3'd1,
        REG_VELOCITY_DECAY = 3'd2,
        REG_GRAVITY_ACCEL  = 3'd3,
        REG_AREA_WIDTH     = 3'd4,
        REG_AREA_HEIGHT    = 3'd5,
        REG_EDGE_OFFSET    = 3'd6
    } pib_reg_idx_t;

    typedef struct packed {
        logic ld1;
        logic ld2;
        logic ld3;
        logic ld4;
        logic ld5;
        logic ld6;
    } pib_ctrl_t;

    localparam logic [1:0] SPEED_SLOW = 2'd0;
    localparam logic [1:0] SPEED_MED  = 2'd1;
    localparam logic [1:0] SPEED_FAST = 2'd2;

    localparam logic [28:0] SLOW_LIM = 29'd262144000;
    localparam logic [28:0] FAST_LIM = 29'd458752000;
    localparam logic [58:0] SLOW_SQ  = 59'(SLOW_LIM) * 59'(SLOW_LIM);
    localparam logic [58:0] FAST_SQ  = 59'(FAST_LIM) * 59'(FAST_LIM);

endpackage
`default_nettype wire

/* design/pib_cfg_regs.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pib_cfg_regs
// APB register bank holding the step, damping, gravity and area settings.
// ----------------------------------------------------------------------------
module pib_cfg_regs (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [4:0]        paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output logic                   pready,
    output pib_pkg::pib_cfg_t      cfg
);

    pib_pkg::pib_cfg_t    cfg_reg;
    pib_pkg::pib_cfg_t    cfg_next;
    pib_pkg::pib_reg_idx_t idx;
    logic                 wr_en;

    assign pready = 1'b1;
    assign idx    = pib_pkg::pib_reg_idx_t'(paddr[4:2]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                pib_pkg::REG_TIME_STEP:      cfg_next.time_step      = pwdata[23:0];
                pib_pkg::REG_WALL_DAMPING:   cfg_next.wall_damping   = pwdata[15:0];
                pib_pkg::REG_VELOCITY_DECAY: cfg_next.velocity_decay = pwdata[15:0];
                pib_pkg::REG_GRAVITY_ACCEL:  cfg_next.gravity_accel  = pwdata[23:0];
                pib_pkg::REG_AREA_WIDTH:     cfg_next.area_width     = pwdata[15:0];
                pib_pkg::REG_AREA_HEIGHT:    cfg_next.area_height    = pwdata[15:0];
                pib_pkg::REG_EDGE_OFFSET:    cfg_next.edge_offset    = pwdata[7:0];
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            pib_pkg::REG_TIME_STEP:      prdata = {8'd0, cfg_reg.time_step};
            pib_pkg::REG_WALL_DAMPING:   prdata = {16'd0, cfg_reg.wall_damping};
            pib_pkg::REG_VELOCITY_DECAY: prdata = {16'd0, cfg_reg.velocity_decay};
            pib_pkg::REG_GRAVITY_ACCEL:  prdata = {8'd0, cfg_reg.gravity_accel};
            pib_pkg::REG_AREA_WIDTH:     prdata = {16'd0, cfg_reg.area_width};
            pib_pkg::REG_AREA_HEIGHT:    prdata = {16'd0, cfg_reg.area_height};
            pib_pkg::REG_EDGE_OFFSET:    prdata = {24'd0, cfg_reg.edge_offset};
            default:                     prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.time_step      <= 24'd33554;
            cfg_reg.wall_damping   <= 16'd58982;
            cfg_reg.velocity_decay <= 16'd60293;
            cfg_reg.gravity_accel  <= 24'd500000;
            cfg_reg.area_width     <= 16'd1280;
            cfg_reg.area_height    <= 16'd800;
            cfg_reg.edge_offset    <= 8'd3;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule
`default_nettype wire

/* design/pib_axis.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pib_axis
// Six-stage datapath of one axis: wall bounce, velocity update, position step.
// ----------------------------------------------------------------------------
module pib_axis (
    input  wire logic                clk,
    input  wire pib_pkg::pib_ctrl_t  ctrl,
    input  wire pib_pkg::pib_cfg_t   cfg,
    input  wire logic [15:0]         area_size,
    input  wire logic signed [31:0]  pos_in,
    input  wire logic signed [39:0]  vel_in,
    input  wire logic signed [47:0]  force_in,
    input  wire logic signed [40:0]  bias_s2,
    output logic signed [39:0]       vel_s4,
    output logic signed [31:0]       pos_out,
    output logic signed [39:0]       vel_out
);

    // Stage 1: wall rule and the first products.
    logic        [31:0] lim;
    logic               hit_lo;
    logic               hit_hi;
    logic        [16:0] hi_diff;
    logic signed [31:0] hi_pos;
    logic signed [40:0] neg_v;
    logic signed [31:0] pos1_next;
    logic signed [57:0] dprod1_next;
    logic signed [60:0] fhi1_next;
    logic signed [60:0] flo1_next;
    logic signed [31:0] pos1_reg;
    logic               hit1_reg;
    logic signed [39:0] vel1_reg;
    logic signed [57:0] dprod1_reg;
    logic signed [60:0] fhi1_reg;
    logic signed [60:0] flo1_reg;

    assign lim     = {area_size, 16'd0};
    assign hit_lo  = pos_in[31] || (pos_in == 32'sd0);
    assign hit_hi  = !hit_lo && (pos_in >= $signed({1'b0, lim}));
    assign hi_diff = {1'b0, area_size} - {9'd0, cfg.edge_offset};
    assign hi_pos  = (!hi_diff[16] && hi_diff[15]) ? 32'sh7FFFFFFF
                                                   : $signed({hi_diff[15:0], 16'd0});
    assign neg_v   = -$signed({vel_in[39], vel_in});

    always_comb
    begin
        if (hit_lo)
        begin
            pos1_next = $signed({8'd0, cfg.edge_offset, 16'd0});
        end
        else if (hit_hi)
        begin
            pos1_next = hi_pos;
        end
        else
        begin
            pos1_next = pos_in;
        end
    end

    assign dprod1_next = neg_v * $signed({1'b0, cfg.wall_damping});
    assign fhi1_next   = force_in * $signed({1'b0, cfg.time_step[23:12]});
    assign flo1_next   = force_in * $signed({1'b0, cfg.time_step[11:0]});

    always_ff @(posedge clk)
    begin
        if (ctrl.ld1)
        begin
            pos1_reg   <= pos1_next;
            hit1_reg   <= hit_lo || hit_hi;
            vel1_reg   <= vel_in;
            dprod1_reg <= dprod1_next;
            fhi1_reg   <= fhi1_next;
            flo1_reg   <= flo1_next;
        end
    end

    // Stage 2: round the bounce velocity and the force term.
    logic signed [57:0] vrnd;
    logic signed [72:0] fsum;
    logic signed [39:0] vel2_next;
    logic signed [49:0] fterm2_next;
    logic signed [31:0] pos2_reg;
    logic signed [39:0] vel2_reg;
    logic signed [49:0] fterm2_reg;

    assign vrnd        = dprod1_reg + 58'sd32768;
    assign vel2_next   = hit1_reg ? vrnd[55:16] : vel1_reg;
    assign fsum        = $signed({fhi1_reg, 12'd0})
                       + $signed({{12{flo1_reg[60]}}, flo1_reg})
                       + 73'sd8388608;
    assign fterm2_next = $signed({fsum[72], fsum[72:24]})
                       + $signed({{9{bias_s2[40]}}, bias_s2});

    always_ff @(posedge clk)
    begin
        if (ctrl.ld2)
        begin
            pos2_reg   <= pos1_reg;
            vel2_reg   <= vel2_next;
            fterm2_reg <= fterm2_next;
        end
    end

    // Stage 3: velocity decay product.
    logic signed [56:0] dec3_next;
    logic signed [31:0] pos3_reg;
    logic signed [49:0] fterm3_reg;
    logic signed [56:0] dec3_reg;

    assign dec3_next = vel2_reg * $signed({1'b0, cfg.velocity_decay});

    always_ff @(posedge clk)
    begin
        if (ctrl.ld3)
        begin
            pos3_reg   <= pos2_reg;
            fterm3_reg <= fterm2_reg;
            dec3_reg   <= dec3_next;
        end
    end

    // Stage 4: new velocity, saturated to 40 bits.
    logic signed [56:0] drnd;
    logic signed [50:0] vsum;
    logic signed [39:0] vel4_next;
    logic signed [31:0] pos4_reg;
    logic signed [39:0] vel4_reg;

    assign drnd = dec3_reg + 57'sd32768;
    assign vsum = $signed({fterm3_reg[49], fterm3_reg})
                + $signed({{10{drnd[56]}}, drnd[56:16]});

    always_comb
    begin
        if (vsum[50:39] == {12{vsum[50]}})
        begin
            vel4_next = vsum[39:0];
        end
        else if (vsum[50])
        begin
            vel4_next = {1'b1, 39'd0};
        end
        else
        begin
            vel4_next = {1'b0, {39{1'b1}}};
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.ld4)
        begin
            pos4_reg <= pos3_reg;
            vel4_reg <= vel4_next;
        end
    end

    assign vel_s4 = vel4_reg;

    // Stage 5: position step product.
    logic signed [64:0] pprod5_next;
    logic signed [31:0] pos5_reg;
    logic signed [39:0] vel5_reg;
    logic signed [64:0] pprod5_reg;

    assign pprod5_next = vel4_reg * $signed({1'b0, cfg.time_step});

    always_ff @(posedge clk)
    begin
        if (ctrl.ld5)
        begin
            pos5_reg   <= pos4_reg;
            vel5_reg   <= vel4_reg;
            pprod5_reg <= pprod5_next;
        end
    end

    // Stage 6: new position, saturated to 32 bits.
    logic signed [64:0] prnd;
    logic signed [41:0] psum;
    logic signed [31:0] pos6_next;
    logic signed [31:0] pos6_reg;
    logic signed [39:0] vel6_reg;

    assign prnd = pprod5_reg + 65'sd8388608;
    assign psum = $signed({{10{pos5_reg[31]}}, pos5_reg})
                + $signed({prnd[64], prnd[64:24]});

    always_comb
    begin
        if (psum[41:31] == {11{psum[41]}})
        begin
            pos6_next = psum[31:0];
        end
        else if (psum[41])
        begin
            pos6_next = 32'sh80000000;
        end
        else
        begin
            pos6_next = 32'sh7FFFFFFF;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.ld6)
        begin
            pos6_reg <= pos6_next;
            vel6_reg <= vel5_reg;
        end
    end

    assign pos_out = pos6_reg;
    assign vel_out = vel6_reg;

endmodule
`default_nettype wire

/* design/pib_speed.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pib_speed
// Two-stage speed classifier: squared magnitude against squared limits.
// ----------------------------------------------------------------------------
module pib_speed (
    input  wire logic                clk,
    input  wire pib_pkg::pib_ctrl_t  ctrl,
    input  wire logic signed [39:0]  vel_x,
    input  wire logic signed [39:0]  vel_y,
    output logic [1:0]               speed_class
);

    logic [39:0] ax;
    logic [39:0] ay;
    logic        fast5_reg;
    logic [57:0] sqx5_reg;
    logic [57:0] sqy5_reg;
    logic [58:0] sum_sq;
    logic [1:0]  cls6_next;
    logic [1:0]  cls6_reg;

    assign ax = vel_x[39] ? 40'(-vel_x) : 40'(vel_x);
    assign ay = vel_y[39] ? 40'(-vel_y) : 40'(vel_y);

    always_ff @(posedge clk)
    begin
        if (ctrl.ld5)
        begin
            fast5_reg <= (ax > 40'(pib_pkg::FAST_LIM)) || (ay > 40'(pib_pkg::FAST_LIM));
            sqx5_reg  <= 58'(ax[28:0]) * 58'(ax[28:0]);
            sqy5_reg  <= 58'(ay[28:0]) * 58'(ay[28:0]);
        end
    end

    assign sum_sq = {1'b0, sqx5_reg} + {1'b0, sqy5_reg};

    always_comb
    begin
        priority if (fast5_reg)
        begin
            cls6_next = pib_pkg::SPEED_FAST;
        end
        else if (sum_sq < pib_pkg::SLOW_SQ)
        begin
            cls6_next = pib_pkg::SPEED_SLOW;
        end
        else if (sum_sq <= pib_pkg::FAST_SQ)
        begin
            cls6_next = pib_pkg::SPEED_MED;
        end
        else
        begin
            cls6_next = pib_pkg::SPEED_FAST;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.ld6)
        begin
            cls6_reg <= cls6_next;
        end
    end

    assign speed_class = cls6_reg;

endmodule
`default_nettype wire

/* design/particle_integrate_bounce_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// particle_integrate_bounce_top
// One fixed-point Euler step with wall bounce for a stream of particles.
// ----------------------------------------------------------------------------
// The block takes one particle transfer per clock cycle until a stalled output
// has filled every stage; six register stages follow the chain of multiplies
// (wall damping, velocity decay, position step); each stage holds its item while
// the output stalls, so bubbles fill up and nothing is lost. The user, not the
// block, must write settings through APB only while no particle is in flight.
module particle_integrate_bounce_top (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [4:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic      [31:0]  prdata,
    output logic              pready,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // pos_x[31:0], pos_y[63:32], vel_x[103:64], vel_y[143:104],
    // force_x[191:144], force_y[239:192]
    input  wire logic [239:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // new_pos_x[31:0], new_pos_y[63:32], new_vel_x[103:64], new_vel_y[143:104],
    // speed_class[145:144], zero[151:146]
    output logic      [151:0] m_tdata
);

    pib_pkg::pib_cfg_t  cfg;
    pib_pkg::pib_ctrl_t ctrl;
    logic [6:1]         valid_reg;
    logic [6:1]         valid_next;
    logic [7:1]         ready;

    pib_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    always_comb
    begin
        ready[7] = m_tready;
        for (int i = 6; i >= 1; i--)
        begin
            ready[i] = !valid_reg[i] || ready[i + 1];
        end
        if (ready[1])
        begin
            valid_next[1] = s_tvalid;
        end
        else
        begin
            valid_next[1] = valid_reg[1];
        end
        for (int i = 2; i <= 6; i++)
        begin
            if (ready[i])
            begin
                valid_next[i] = valid_reg[i - 1];
            end
            else
            begin
                valid_next[i] = valid_reg[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign ctrl.ld1 = ready[1];
    assign ctrl.ld2 = ready[2];
    assign ctrl.ld3 = ready[3];
    assign ctrl.ld4 = ready[4];
    assign ctrl.ld5 = ready[5];
    assign ctrl.ld6 = ready[6];

    assign s_tready = ready[1];
    assign m_tvalid = valid_reg[6];

    logic [47:0] gdt1_reg;
    logic [47:0] grnd;
    logic signed [40:0] gbias;

    always_ff @(posedge clk)
    begin
        if (ctrl.ld1)
        begin
            gdt1_reg <= 48'(cfg.gravity_accel) * 48'(cfg.time_step);
        end
    end

    assign grnd  = gdt1_reg + 48'd128;
    assign gbias = $signed({1'b0, grnd[47:8]});

    logic signed [39:0] vx_s4;
    logic signed [39:0] vy_s4;
    logic signed [31:0] px_out;
    logic signed [31:0] py_out;
    logic signed [39:0] vx_out;
    logic signed [39:0] vy_out;
    logic [1:0]         cls_out;

    pib_axis u_axis_x (
        .clk       (clk),
        .ctrl      (ctrl),
        .cfg       (cfg),
        .area_size (cfg.area_width),
        .pos_in    ($signed(s_tdata[31:0])),
        .vel_in    ($signed(s_tdata[103:64])),
        .force_in  ($signed(s_tdata[191:144])),
        .bias_s2   (41'sd0),
        .vel_s4    (vx_s4),
        .pos_out   (px_out),
        .vel_out   (vx_out)
    );

    pib_axis u_axis_y (
        .clk       (clk),
        .ctrl      (ctrl),
        .cfg       (cfg),
        .area_size (cfg.area_height),
        .pos_in    ($signed(s_tdata[63:32])),
        .vel_in    ($signed(s_tdata[143:104])),
        .force_in  ($signed(s_tdata[239:192])),
        .bias_s2   (gbias),
        .vel_s4    (vy_s4),
        .pos_out   (py_out),
        .vel_out   (vy_out)
    );

    pib_speed u_speed (
        .clk         (clk),
        .ctrl        (ctrl),
        .vel_x       (vx_s4),
        .vel_y       (vy_s4),
        .speed_class (cls_out)
    );

    assign m_tdata = {6'd0, cls_out, vy_out, vx_out, py_out, px_out};

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> valid_reg[1])
        else $error("accepted transfer did not enter the first stage");

    a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (($countones(valid_reg) == 6) && !m_tready) |-> !s_tready)
        else $error("input accepted while every stage is full and stalled");

    a_class_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[145:144] != 2'd3))
        else $error("speed class code out of range");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[5] && valid_reg[6] && !m_tready) |=> valid_reg[5])
        else $error("stalled stage lost its item");

endmodule
`default_nettype wire
